@@ rtl/dbli_pkg.sv @@
// Shared types, constants and helpers for the depth bracket interpolator.
`default_nettype none

package dbli_pkg;

    localparam int OP_W     = 2;
    localparam int SIDX_W   = 4;
    localparam int COL_W    = 6;
    localparam int ELEV_W   = 10;
    localparam int Q_W      = 20;
    localparam int VAL_W    = 24;
    localparam int STAT_W   = 2;
    localparam int CFG_W    = 5;
    localparam int PROP_W   = 3 * VAL_W;
    localparam int POS_W    = 21;
    localparam int DEN_W    = 20;
    localparam int QUOT_W   = 24;
    localparam int NUM_W    = DEN_W + QUOT_W;
    localparam int KM_TO_M  = 1000;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd14;
    localparam int MIN_SURFACES = 2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_ELEV = 2'd0,
        OP_LOAD_COL  = 2'd1,
        OP_QUERY     = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_ABOVE = 2'd1,
        ST_BELOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [VAL_W-1:0]  density;
        logic [VAL_W-1:0]  swave;
        logic [VAL_W-1:0]  pwave;
        logic [STAT_W-1:0] status;
    } result_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_rsp_t;

    // Surface elevation in metres.
    function automatic logic signed [POS_W-1:0] pos_of(input logic signed [ELEV_W-1:0] e);
        return POS_W'(e) * POS_W'(KM_TO_M);
    endfunction

endpackage

`default_nettype wire

@@ rtl/dbli_if.sv @@
// Item and result channel interfaces of the depth bracket interpolator.
`default_nettype none

interface dbli_item_if;
    logic                                valid;
    logic                                ready;
    logic [dbli_pkg::OP_W-1:0]           operation;
    logic [dbli_pkg::SIDX_W-1:0]         surface_index;
    logic [dbli_pkg::COL_W-1:0]          column_x;
    logic [dbli_pkg::COL_W-1:0]          column_y;
    logic signed [dbli_pkg::ELEV_W-1:0]  surface_elev_km;
    logic signed [dbli_pkg::Q_W-1:0]     query_elev_m;
    logic [dbli_pkg::VAL_W-1:0]          density_in;
    logic [dbli_pkg::VAL_W-1:0]          swave_in;
    logic [dbli_pkg::VAL_W-1:0]          pwave_in;

    modport source (
        output valid, operation, surface_index, column_x, column_y,
               surface_elev_km, query_elev_m, density_in, swave_in, pwave_in,
        input  ready
    );
    modport sink (
        input  valid, operation, surface_index, column_x, column_y,
               surface_elev_km, query_elev_m, density_in, swave_in, pwave_in,
        output ready
    );
endinterface

interface dbli_result_if;
    logic                         valid;
    logic                         ready;
    logic [dbli_pkg::VAL_W-1:0]   density_out;
    logic [dbli_pkg::VAL_W-1:0]   swave_out;
    logic [dbli_pkg::VAL_W-1:0]   pwave_out;
    logic [dbli_pkg::STAT_W-1:0]  status;

    modport source (
        output valid, density_out, swave_out, pwave_out, status,
        input  ready
    );
    modport sink (
        input  valid, density_out, swave_out, pwave_out, status,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/dbli_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module dbli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/dbli_div.sv @@
// Radix-2 restoring divider that yields one quotient bit per cycle.
`default_nettype none

module dbli_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dbli_pkg::div_req_t req,
    output dbli_pkg::div_rsp_t      rsp
);

    localparam int DEN_W  = dbli_pkg::DEN_W;
    localparam int QUOT_W = dbli_pkg::QUOT_W;
    localparam int NUM_W  = dbli_pkg::NUM_W;
    localparam int CNT_W  = $clog2(QUOT_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [QUOT_W-1:0] qsh_reg, qsh_next;

    always_comb
    begin
        logic [DEN_W:0] trial;
        logic           qbit;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        qsh_next  = qsh_reg;
        trial     = {rem_reg, qsh_reg[QUOT_W-1]};
        qbit      = (trial >= {1'b0, den_reg});
        if (req.start)
        begin
            // The quotient is known to fit, so the top bits are below the divisor.
            rem_next  = req.num[NUM_W-1:QUOT_W];
            qsh_next  = req.num[QUOT_W-1:0];
            den_next  = req.den;
            cnt_next  = CNT_W'(QUOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
            qsh_next = {qsh_reg[QUOT_W-2:0], qbit};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        qsh_reg <= qsh_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = qsh_reg;

endmodule

`default_nettype wire

@@ rtl/dbli_ctrl.sv @@
// Query sequencer: surface search through the memories and interpolation of three values.
`default_nettype none

module dbli_ctrl #(
    parameter int SW  = 4,
    parameter int CAW = 12,
    parameter int CW  = 5
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [dbli_pkg::Q_W-1:0]   q,
    input  wire logic [CW-1:0]                     n,
    input  wire logic [CAW-1:0]                    col,
    input  wire logic                              out_free,
    input  wire logic [dbli_pkg::ELEV_W-1:0]       elev_rdata,
    input  wire logic [dbli_pkg::PROP_W-1:0]       prop_rdata,
    input  wire dbli_pkg::div_rsp_t                div_rsp,
    output logic                                   busy,
    output logic                                   elev_re,
    output logic [SW-1:0]                          elev_raddr,
    output logic                                   prop_re,
    output logic [SW+CAW-1:0]                      prop_raddr,
    output logic                                   res_valid,
    output dbli_pkg::result_t                      res,
    output dbli_pkg::div_req_t                     div_req
);

    localparam int Q_W    = dbli_pkg::Q_W;
    localparam int VAL_W  = dbli_pkg::VAL_W;
    localparam int POS_W  = dbli_pkg::POS_W;
    localparam int DEN_W  = dbli_pkg::DEN_W;
    localparam int NUM_W  = dbli_pkg::NUM_W;
    localparam int STAT_W = dbli_pkg::STAT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DIFF,
        S_MAG,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_ACC,
        S_FINISH
    } state_t;

    state_t                        state_reg, state_next;
    logic [CW-1:0]                 s_reg, s_next;
    logic [1:0]                    k_reg, k_next;
    logic signed [Q_W-1:0]         q_reg, q_next;
    logic [CW-1:0]                 n_reg, n_next;
    logic [CAW-1:0]                col_reg, col_next;
    logic signed [POS_W-1:0]       prev_pos_reg, prev_pos_next;
    logic signed [POS_W-1:0]       cur_pos_reg, cur_pos_next;
    logic [2:0][VAL_W-1:0]         prev_val_reg, prev_val_next;
    logic [2:0][VAL_W-1:0]         cur_val_reg, cur_val_next;
    logic [2:0][VAL_W-1:0]         res_val_reg, res_val_next;
    logic [STAT_W-1:0]             status_reg, status_next;
    logic [DEN_W-1:0]              d_reg, d_next;
    logic [DEN_W-1:0]              off_reg, off_next;
    logic [VAL_W-1:0]              mag_reg, mag_next;
    logic                          neg_reg, neg_next;
    logic [NUM_W-1:0]              num_reg, num_next;

    always_comb
    begin
        logic signed [POS_W-1:0] pos;
        logic [VAL_W-1:0]        v1;
        logic [VAL_W-1:0]        v2;
        state_next    = state_reg;
        s_next        = s_reg;
        k_next        = k_reg;
        q_next        = q_reg;
        n_next        = n_reg;
        col_next      = col_reg;
        prev_pos_next = prev_pos_reg;
        cur_pos_next  = cur_pos_reg;
        prev_val_next = prev_val_reg;
        cur_val_next  = cur_val_reg;
        res_val_next  = res_val_reg;
        status_next   = status_reg;
        d_next        = d_reg;
        off_next      = off_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        num_next      = num_reg;
        pos           = dbli_pkg::pos_of(elev_rdata);
        v1            = prev_val_reg[k_reg];
        v2            = cur_val_reg[k_reg];
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    q_next     = q;
                    n_next     = n;
                    col_next   = col;
                    s_next     = '0;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (POS_W'(q_reg) < pos)
                begin
                    // Query lies below this surface; move one surface down.
                    prev_pos_next = pos;
                    prev_val_next = prop_rdata;
                    s_next        = s_reg + CW'(1);
                    if (s_reg + CW'(1) >= n_reg)
                    begin
                        res_val_next = '0;
                        status_next  = dbli_pkg::ST_BELOW;
                        state_next   = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
                else if (s_reg == '0)
                begin
                    res_val_next = '0;
                    status_next  = dbli_pkg::ST_ABOVE;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cur_pos_next = pos;
                    cur_val_next = prop_rdata;
                    state_next   = S_DIFF;
                end
            end
            S_DIFF:
            begin
                d_next     = DEN_W'(prev_pos_reg - cur_pos_reg);
                off_next   = DEN_W'(prev_pos_reg - POS_W'(q_reg));
                k_next     = '0;
                state_next = S_MAG;
            end
            S_MAG:
            begin
                neg_next   = (v2 < v1);
                mag_next   = (v2 < v1) ? (v1 - v2) : (v2 - v1);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                num_next   = NUM_W'(mag_reg) * NUM_W'(off_reg) + NUM_W'(d_reg >> 1);
                state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                // The rounded step never exceeds the distance to v2, so no clamp is needed.
                res_val_next[k_reg] = neg_reg ? (v1 - div_rsp.quot) : (v1 + div_rsp.quot);
                if (k_reg == 2'd2)
                begin
                    status_next = dbli_pkg::ST_OK;
                    state_next  = S_FINISH;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_MAG;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            s_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            s_reg     <= s_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        n_reg        <= n_next;
        col_reg      <= col_next;
        prev_pos_reg <= prev_pos_next;
        cur_pos_reg  <= cur_pos_next;
        prev_val_reg <= prev_val_next;
        cur_val_reg  <= cur_val_next;
        res_val_reg  <= res_val_next;
        status_reg   <= status_next;
        d_reg        <= d_next;
        off_reg      <= off_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        num_reg      <= num_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign elev_re    = (state_reg == S_SCAN_RD);
    assign prop_re    = (state_reg == S_SCAN_RD);
    assign elev_raddr = SW'(s_reg);
    assign prop_raddr = {SW'(s_reg), col_reg};
    assign res_valid  = (state_reg == S_FINISH);

    assign res.density = res_val_reg[2];
    assign res.swave   = res_val_reg[1];
    assign res.pwave   = res_val_reg[0];
    assign res.status  = status_reg;

    assign div_req.start = (state_reg == S_DIV_GO);
    assign div_req.num   = num_reg;
    assign div_req.den   = d_reg;

endmodule

`default_nettype wire

@@ rtl/depth_bracket_linear_interp.sv @@
// Top level of the depth bracket interpolator: loads, memories, sequencer and output register.
//
//   Channel   Direction  Handshake     Carries
//   item      sink       valid/ready   load or query transaction
//   result    source     valid/ready   interpolated values and status
//   cfg       write      cfg_we        surfaces_in_use
//
// A load transaction writes its memory at the accepting edge.
// A query reads the elevation and property memories for each surface examined, then
// runs the bit-serial divider once for each of its three values.
// A query that lands above the top or below the last surface skips the divider.
// Memories are not cleared by reset; a finished result waits in the output register.
`default_nettype none

module depth_bracket_linear_interp #(
    parameter int MAX_SURFACES = 16,
    parameter int GRID_X       = 64,
    parameter int GRID_Y       = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [dbli_pkg::CFG_W-1:0]  cfg_wdata,
    dbli_item_if.sink                        item,
    dbli_result_if.source                    result
);

    localparam int XW     = (GRID_X > 1) ? $clog2(GRID_X) : 1;
    localparam int YW     = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
    localparam int SW     = $clog2(MAX_SURFACES);
    localparam int CW     = $clog2(MAX_SURFACES + 1);
    localparam int CAW    = XW + YW;
    localparam int PDEPTH = MAX_SURFACES * (2 ** CAW);

    logic [dbli_pkg::CFG_W-1:0] cfg_reg;
    logic                       accept;
    logic                       start;
    logic                       si_ok;
    logic                       col_ok;
    logic [XW-1:0]              qx;
    logic [YW-1:0]              qy;
    logic [CW-1:0]              n_sat;
    logic                       elev_we;
    logic                       prop_we;
    logic                       elev_re;
    logic                       prop_re;
    logic [SW-1:0]              elev_raddr;
    logic [SW+CAW-1:0]          prop_raddr;
    logic [dbli_pkg::ELEV_W-1:0] elev_rdata;
    logic [dbli_pkg::PROP_W-1:0] prop_rdata;
    logic                       busy;
    logic                       res_valid;
    logic                       out_free;
    logic                       out_valid_reg, out_valid_next;
    dbli_pkg::result_t          res;
    dbli_pkg::result_t          out_data_reg;
    dbli_pkg::div_req_t         div_req;
    dbli_pkg::div_rsp_t         div_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= dbli_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            cfg_reg <= cfg_wdata;
        end
    end

    assign item.ready = !busy;
    assign accept     = item.valid && item.ready;
    assign start      = accept && (item.operation == dbli_pkg::OP_QUERY);

    assign si_ok  = (int'(item.surface_index) < MAX_SURFACES);
    assign col_ok = (int'(item.column_x) < GRID_X) && (int'(item.column_y) < GRID_Y);

    assign qx = (int'(item.column_x) >= GRID_X) ? XW'(GRID_X - 1) : XW'(item.column_x);
    assign qy = (int'(item.column_y) >= GRID_Y) ? YW'(GRID_Y - 1) : YW'(item.column_y);

    assign n_sat = (int'(cfg_reg) < dbli_pkg::MIN_SURFACES) ? CW'(dbli_pkg::MIN_SURFACES) :
                   (int'(cfg_reg) > MAX_SURFACES) ? CW'(MAX_SURFACES) : CW'(cfg_reg);

    assign elev_we = accept && (item.operation == dbli_pkg::OP_LOAD_ELEV) && si_ok;
    assign prop_we = accept && (item.operation == dbli_pkg::OP_LOAD_COL) && si_ok && col_ok;

    dbli_ram #(
        .WIDTH (dbli_pkg::ELEV_W),
        .DEPTH (MAX_SURFACES)
    ) u_elev_ram (
        .clk   (clk),
        .we    (elev_we),
        .waddr (SW'(item.surface_index)),
        .wdata (item.surface_elev_km),
        .re    (elev_re),
        .raddr (elev_raddr),
        .rdata (elev_rdata)
    );

    dbli_ram #(
        .WIDTH (dbli_pkg::PROP_W),
        .DEPTH (PDEPTH)
    ) u_prop_ram (
        .clk   (clk),
        .we    (prop_we),
        .waddr ({SW'(item.surface_index), XW'(item.column_x), YW'(item.column_y)}),
        .wdata ({item.density_in, item.swave_in, item.pwave_in}),
        .re    (prop_re),
        .raddr (prop_raddr),
        .rdata (prop_rdata)
    );

    dbli_ctrl #(
        .SW  (SW),
        .CAW (CAW),
        .CW  (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .q          (item.query_elev_m),
        .n          (n_sat),
        .col        ({qx, qy}),
        .out_free   (out_free),
        .elev_rdata (elev_rdata),
        .prop_rdata (prop_rdata),
        .div_rsp    (div_rsp),
        .busy       (busy),
        .elev_re    (elev_re),
        .elev_raddr (elev_raddr),
        .prop_re    (prop_re),
        .prop_raddr (prop_raddr),
        .res_valid  (res_valid),
        .res        (res),
        .div_req    (div_req)
    );

    dbli_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_free       = !out_valid_reg || result.ready;
    assign out_valid_next = (res_valid && out_free) || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && out_free)
        begin
            out_data_reg <= res;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.density_out = out_data_reg.density;
    assign result.swave_out   = out_data_reg.swave;
    assign result.pwave_out   = out_data_reg.pwave;
    assign result.status      = out_data_reg.status;

endmodule

`default_nettype wire

@@ rtl/dbli_chk.sv @@
// Port-level checker for the depth bracket interpolator and its bind statement.
`default_nettype none

module dbli_chk (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         item_valid,
    input wire logic                         item_ready,
    input wire logic [dbli_pkg::OP_W-1:0]    item_operation,
    input wire logic                         result_valid,
    input wire logic                         result_ready,
    input wire logic [dbli_pkg::VAL_W-1:0]   result_density,
    input wire logic [dbli_pkg::VAL_W-1:0]   result_swave,
    input wire logic [dbli_pkg::VAL_W-1:0]   result_pwave,
    input wire logic [dbli_pkg::STAT_W-1:0]  result_status
);

    // A result transaction stays offered until it is taken.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result valid dropped before the transaction completed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_status == dbli_pkg::ST_OK) ||
                         (result_status == dbli_pkg::ST_ABOVE) ||
                         (result_status == dbli_pkg::ST_BELOW))
        else $error("result carries an unused status code");

    // A query outside the bracketed range returns zero values.
    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_status != dbli_pkg::ST_OK) |->
            (result_density == '0) && (result_swave == '0) && (result_pwave == '0))
        else $error("out-of-range query returned nonzero values");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item_operation == dbli_pkg::OP_QUERY) |=> !item_ready)
        else $error("item channel ready while a query is in progress");

    a_load_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item_operation != dbli_pkg::OP_QUERY) |=> item_ready)
        else $error("item channel stalled after a load transaction");

endmodule

bind depth_bracket_linear_interp dbli_chk u_dbli_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (item.valid),
    .item_ready     (item.ready),
    .item_operation (item.operation),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_density (result.density_out),
    .result_swave   (result.swave_out),
    .result_pwave   (result.pwave_out),
    .result_status  (result.status)
);

`default_nettype wire
